// ----- design/irk_pkg.sv -----
// Shared key codes and decoded-key type for the infrared keypad number entry unit.
package irk_pkg;

    localparam logic [31:0] KEY_ONE    = 32'd4077715200;
    localparam logic [31:0] KEY_TWO    = 32'd3877175040;
    localparam logic [31:0] KEY_THREE  = 32'd2707357440;
    localparam logic [31:0] KEY_FOUR   = 32'd4144561920;
    localparam logic [31:0] KEY_FIVE   = 32'd3810328320;
    localparam logic [31:0] KEY_SIX    = 32'd2774204160;
    localparam logic [31:0] KEY_SEVEN  = 32'd3175284480;
    localparam logic [31:0] KEY_EIGHT  = 32'd2907897600;
    localparam logic [31:0] KEY_NINE   = 32'd3041591040;
    localparam logic [31:0] KEY_ZERO   = 32'd3910598400;
    localparam logic [31:0] KEY_EQUALS = 32'd4127850240;
    localparam logic [31:0] KEY_MINUS  = 32'd4161273600;

    localparam int unsigned CODE_W  = 32;
    localparam int unsigned REP_W   = 8;
    localparam int unsigned ACC_W   = 32;
    localparam int unsigned DIGIT_W = 4;

    typedef struct packed {
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
        logic               is_equals;
        logic               is_minus;
    } key_dec_t;

endpackage

// ----- design/irk_key_decode.sv -----
// Maps a remote key code onto digit, equals and minus indications.
module irk_key_decode (
    input  logic [irk_pkg::CODE_W-1:0] code,
    output irk_pkg::key_dec_t          dec
);
    import irk_pkg::*;

    always_comb begin
        dec = '0;
        case (code)
            KEY_ZERO:   begin dec.is_digit = 1'b1; dec.digit = 4'd0; end
            KEY_ONE:    begin dec.is_digit = 1'b1; dec.digit = 4'd1; end
            KEY_TWO:    begin dec.is_digit = 1'b1; dec.digit = 4'd2; end
            KEY_THREE:  begin dec.is_digit = 1'b1; dec.digit = 4'd3; end
            KEY_FOUR:   begin dec.is_digit = 1'b1; dec.digit = 4'd4; end
            KEY_FIVE:   begin dec.is_digit = 1'b1; dec.digit = 4'd5; end
            KEY_SIX:    begin dec.is_digit = 1'b1; dec.digit = 4'd6; end
            KEY_SEVEN:  begin dec.is_digit = 1'b1; dec.digit = 4'd7; end
            KEY_EIGHT:  begin dec.is_digit = 1'b1; dec.digit = 4'd8; end
            KEY_NINE:   begin dec.is_digit = 1'b1; dec.digit = 4'd9; end
            KEY_EQUALS: dec.is_equals = 1'b1;
            KEY_MINUS:  dec.is_minus  = 1'b1;
            default:    dec = '0;
        endcase
    end

endmodule

// ----- design/ir_keypad_number_entry_unit.sv -----
// Top level of the infrared keypad number entry unit: fresh-press detection and accumulator.
//
// Each input beat carries a decoded remote code and the receiver's repeat count, and
// produces exactly one result beat. A press counts as fresh when a nonzero code differs
// from the last stored code with a nonzero repeat count, or when the repeat count changes
// to one. A fresh digit key appends the digit to a decimal accumulator that saturates at
// 4294967295, the minus key clears it, and the equals key reports the value with
// m_value_ready high and then clears it; each of these raises m_beep. The unit has an
// input register and a result register with decode, multiply-by-ten and saturate logic
// between them, so a beat is accepted every cycle while results are taken; its result is
// presented on the m_ side once the input register hands it on. While the result
// register waits for m_ready, the input register can still take one more beat if it is
// empty; after that s_ready stays low until the result is taken. Throughput stays at one
// beat per cycle as long as the downstream side keeps taking results.
module ir_keypad_number_entry_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [irk_pkg::CODE_W-1:0]  s_ir_code,
    input  logic [irk_pkg::REP_W-1:0]   s_repeat_count,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_value_ready,
    output logic [irk_pkg::ACC_W-1:0]   m_entered_value,
    output logic                        m_beep
);
    import irk_pkg::*;

    // Input register stage.
    logic              in_valid_reg;
    logic [CODE_W-1:0] in_code_reg;
    logic [REP_W-1:0]  in_rep_reg;

    // Persistent key state.
    logic [CODE_W-1:0] last_code_reg, last_code_next;
    logic [REP_W-1:0]  prev_rep_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;

    // Result register stage.
    logic              out_valid_reg;
    logic              out_ready_flag_reg, out_ready_flag_next;
    logic [ACC_W-1:0]  out_value_reg, out_value_next;
    logic              out_beep_reg, out_beep_next;

    logic              advance;
    logic              new_code;
    logic              fresh;
    logic [CODE_W-1:0] key_code;
    key_dec_t          dec;
    logic [ACC_W+3:0]  acc_times_ten;
    logic [ACC_W+3:0]  acc_sum;

    // The input stage moves into the result stage whenever the result stage is free
    // or being emptied this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // A new nonzero code with a nonzero repeat count replaces the stored code; a change
    // of the repeat count to one re-triggers the stored key.
    assign new_code = (in_code_reg != '0) && (in_code_reg != last_code_reg)
                      && (in_rep_reg != '0);
    assign fresh    = new_code
                      || ((prev_rep_reg != in_rep_reg) && (in_rep_reg == REP_W'(1)));
    assign key_code = new_code ? in_code_reg : last_code_reg;

    irk_key_decode u_key_decode (
        .code (key_code),
        .dec  (dec)
    );

    // Times ten as two shifted copies, then the digit; anything above 32 bits saturates.
    assign acc_times_ten = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
    assign acc_sum       = acc_times_ten + (ACC_W + 4)'(dec.digit);

    always_comb begin
        last_code_next      = key_code;
        acc_next            = acc_reg;
        out_ready_flag_next = 1'b0;
        out_value_next      = '0;
        out_beep_next       = 1'b0;
        if (fresh) begin
            if (dec.is_digit) begin
                acc_next      = (acc_sum[ACC_W+3:ACC_W] != '0) ? '1 : acc_sum[ACC_W-1:0];
                out_beep_next = 1'b1;
            end else if (dec.is_equals) begin
                out_ready_flag_next = 1'b1;
                out_value_next      = acc_reg;
                acc_next            = '0;
                out_beep_next       = 1'b1;
            end else if (dec.is_minus) begin
                acc_next      = '0;
                out_beep_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_code_reg <= '0;
            prev_rep_reg  <= '0;
            acc_reg       <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                last_code_reg <= last_code_next;
                prev_rep_reg  <= in_rep_reg;
                acc_reg       <= acc_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_code_reg <= s_ir_code;
            in_rep_reg  <= s_repeat_count;
        end
        if (advance) begin
            out_ready_flag_reg <= out_ready_flag_next;
            out_value_reg      <= out_value_next;
            out_beep_reg       <= out_beep_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_value_ready   = out_ready_flag_reg;
    assign m_entered_value = out_value_reg;
    assign m_beep          = out_beep_reg;

`ifndef SYNTHESIS
    // A completed entry is always announced with a beep.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_value_ready) |-> m_beep)
        else $error("value ready without beep");

    // The value field is zero unless an entry completed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_value_ready) |-> (m_entered_value == '0))
        else $error("nonzero value without ready flag");

    // Equals and minus leave the accumulator cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && fresh && (dec.is_equals || dec.is_minus)) |=> (acc_reg == '0))
        else $error("accumulator not cleared");

    // A beat that is not fresh leaves the accumulator as it was.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !fresh) |=> $stable(acc_reg))
        else $error("accumulator changed without fresh press");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the infrared keypad number entry unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import irk_pkg::*;

    // One result beat, in the order of the result ports.
    typedef struct packed {
        logic              value_ready;
        logic [ACC_W-1:0]  entered_value;
        logic              beep;
    } result_t;

    // One row of the directed table. Rows with has_want set carry an expectation
    // that is obvious by inspection; all other rows are checked against the
    // predictor.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [REP_W-1:0]  rep;
        logic              has_want;
        result_t           want;
    } key_row_t;

    localparam int unsigned  RAND_BEATS  = 850;
    localparam int unsigned  PAUSE_AT    = 400;
    localparam int unsigned  QUIET_LIMIT = 2000;
    localparam int unsigned  DRAIN_WAIT  = 10;
    localparam logic [ACC_W-1:0] ACC_FULL = '1;
    localparam result_t      NO_WANT     = '{1'b0, 32'd0, 1'b0};

    localparam logic [CODE_W-1:0] DIGIT_KEYS [10] = '{
        KEY_ZERO, KEY_ONE, KEY_TWO, KEY_THREE, KEY_FOUR,
        KEY_FIVE, KEY_SIX, KEY_SEVEN, KEY_EIGHT, KEY_NINE
    };

    // Directed sequence, starting from reset. The first digit run grows past
    // 32 bits so that the accumulator saturates before equals reports it.
    localparam int unsigned DIR_N = 25;
    localparam key_row_t DIR_ROWS [DIR_N] = '{
        '{32'd0,        8'd0,   1'b1, '{1'b0, 32'd0, 1'b0}},  // nothing received
        '{KEY_EQUALS,   8'd1,   1'b1, '{1'b1, 32'd0, 1'b1}},  // equals on empty entry
        '{KEY_ONE,      8'd2,   1'b0, NO_WANT},               // new code, repeat not 1
        '{KEY_ONE,      8'd2,   1'b0, NO_WANT},               // held key, no new press
        '{KEY_ONE,      8'd1,   1'b0, NO_WANT},               // repeat drops to 1
        '{32'd0,        8'd1,   1'b0, NO_WANT},
        '{32'd0,        8'd0,   1'b0, NO_WANT},
        '{32'd0,        8'd1,   1'b0, NO_WANT},               // re-press of stored key
        '{KEY_TWO,      8'd3,   1'b0, NO_WANT},
        '{KEY_THREE,    8'd4,   1'b0, NO_WANT},
        '{KEY_FOUR,     8'd5,   1'b0, NO_WANT},
        '{KEY_FIVE,     8'd6,   1'b0, NO_WANT},
        '{KEY_SIX,      8'd7,   1'b0, NO_WANT},
        '{KEY_SEVEN,    8'd8,   1'b0, NO_WANT},
        '{KEY_EIGHT,    8'd9,   1'b0, NO_WANT},
        '{KEY_NINE,     8'd10,  1'b0, NO_WANT},               // overflows, saturates
        '{KEY_ZERO,     8'd11,  1'b0, NO_WANT},               // stays saturated
        '{KEY_EQUALS,   8'd12,  1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b1}},
        '{KEY_FIVE,     8'd1,   1'b0, NO_WANT},
        '{KEY_MINUS,    8'd2,   1'b1, '{1'b0, 32'd0, 1'b1}},  // minus clears
        '{KEY_EQUALS,   8'd3,   1'b1, '{1'b1, 32'd0, 1'b1}},
        '{32'hFFFF_FFFF, 8'd255, 1'b1, '{1'b0, 32'd0, 1'b0}}, // unknown code
        '{32'h0000_0001, 8'd128, 1'b1, '{1'b0, 32'd0, 1'b0}}, // unknown code
        '{KEY_ZERO,     8'd1,   1'b0, NO_WANT},
        '{KEY_EQUALS,   8'd255, 1'b0, NO_WANT}
    };

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [CODE_W-1:0]   s_ir_code       = '0;
    logic [REP_W-1:0]    s_repeat_count  = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic                m_value_ready;
    logic [ACC_W-1:0]    m_entered_value;
    logic                m_beep;

    // While calm is set neither side inserts idle cycles.
    logic                calm            = 1'b0;
    int unsigned         rx_hold         = 0;
    int unsigned         quiet_cycles    = 0;
    int unsigned         mismatch_count  = 0;

    // Mirror of the unit's state, advanced once per accepted input beat.
    logic [CODE_W-1:0]   mirror_last_code = '0;
    logic [REP_W-1:0]    mirror_prev_rep  = '0;
    logic [ACC_W-1:0]    mirror_acc       = '0;

    // Results that have been predicted but not yet seen, oldest first.
    result_t             pending_results [$];

    ir_keypad_number_entry_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ir_code       (s_ir_code),
        .s_repeat_count  (s_repeat_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value_ready   (m_value_ready),
        .m_entered_value (m_entered_value),
        .m_beep          (m_beep)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Computes the result for one input beat and advances the mirrored state.
    // A press is new when a nonzero code differs from the stored one with a
    // nonzero repeat count, or when the repeat count steps to exactly one; in
    // both cases the key acted on is the stored code after the update.
    function automatic result_t keypad_predict(input logic [CODE_W-1:0] code,
                                               input logic [REP_W-1:0] rep);
        result_t     res;
        logic        fresh;
        logic [35:0] grown;
        int          digit;
        res   = NO_WANT;
        fresh = 1'b0;
        digit = -1;
        if (code != '0 && code != mirror_last_code && rep != '0) begin
            mirror_last_code = code;
            fresh = 1'b1;
        end
        if (rep != mirror_prev_rep && rep == 8'd1) begin
            fresh = 1'b1;
        end
        if (fresh) begin
            for (int i = 0; i < 10; i++) begin
                if (DIGIT_KEYS[i] == mirror_last_code) begin
                    digit = i;
                end
            end
            if (digit >= 0) begin
                // Append the digit; anything beyond 32 bits pins at all ones.
                grown = 36'(mirror_acc) * 36'd10 + 36'(digit);
                mirror_acc = (grown > 36'(ACC_FULL)) ? ACC_FULL : grown[ACC_W-1:0];
                res.beep = 1'b1;
            end else if (mirror_last_code == KEY_EQUALS) begin
                res.value_ready   = 1'b1;
                res.entered_value = mirror_acc;
                res.beep          = 1'b1;
                mirror_acc        = '0;
            end else if (mirror_last_code == KEY_MINUS) begin
                mirror_acc = '0;
                res.beep   = 1'b1;
            end
        end
        mirror_prev_rep = rep;
        return res;
    endfunction

    // Presents one input beat, holds it until it is taken, and queues what it
    // should produce. A random idle burst may come first unless calm is set.
    // The predictor always runs so that its state stays in step; a typed-in
    // expectation, where given, replaces its answer.
    task automatic send_beat(input logic [CODE_W-1:0] code, input logic [REP_W-1:0] rep,
                             input logic has_want, input result_t want);
        result_t predicted;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_ir_code      <= code;
        s_repeat_count <= rep;
        do @(posedge aclk); while (!s_ready);
        predicted = keypad_predict(code, rep);
        pending_results.push_back(has_want ? want : predicted);
    endtask

    // Takes the valid line low and waits until every queued result has come.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Result side: m_ready drops low in random bursts except
    // while calm is set.
    always @(posedge aclk) begin
        if (!calm && rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            rx_hold <= $urandom_range(1, 18) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every accepted result beat is compared field by field with the oldest
    // pending expectation.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat ready=%0b value=%0d beep=%0b",
                                          m_value_ready, m_entered_value, m_beep));
            end else begin
                want = pending_results.pop_front();
                if (m_value_ready !== want.value_ready) begin
                    report_mismatch($sformatf("value_ready got %0b want %0b",
                                              m_value_ready, want.value_ready));
                end
                if (m_entered_value !== want.entered_value) begin
                    report_mismatch($sformatf("entered_value got %0d want %0d",
                                              m_entered_value, want.entered_value));
                end
                if (m_beep !== want.beep) begin
                    report_mismatch($sformatf("beep got %0b want %0b", m_beep, want.beep));
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no beat on either side means the
    // unit has hung or lost a result.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Main stimulus. The directed table runs first from reset, then random
    // traffic made mostly of well-formed key presses: a first frame with the
    // key code, a few repeat frames with the same code or no code, and often
    // a release frame with a zero repeat count. Long digit runs push the
    // accumulator into saturation now and then, and a share of pure noise
    // beats carries arbitrary codes and repeat counts.
    initial begin
        int unsigned       rnd_sent;
        int unsigned       kind;
        int unsigned       frames;
        int unsigned       sel;
        bit                paused;
        logic [CODE_W-1:0] key;
        logic [CODE_W-1:0] code;
        logic [REP_W-1:0]  rep;

        rnd_sent = 0;
        paused   = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++) begin
            send_beat(DIR_ROWS[i].code, DIR_ROWS[i].rep, DIR_ROWS[i].has_want,
                      DIR_ROWS[i].want);
        end
        wait_drained();

        while (rnd_sent < RAND_BEATS) begin
            // A calm stretch in the middle and no idling at all near the end.
            calm = (rnd_sent >= 300 && rnd_sent < 380) || rnd_sent >= RAND_BEATS - 90;
            kind = $urandom_range(0, 19);
            if (kind < 2) begin
                code = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom());
                rep  = 8'($urandom_range(0, 255));
                send_beat(code, rep, 1'b0, NO_WANT);
                rnd_sent++;
            end else if (kind == 2) begin
                // Long entry: each digit is pressed and released, then equals.
                frames = $urandom_range(9, 13);
                for (int f = 0; f < frames; f++) begin
                    send_beat(DIGIT_KEYS[$urandom_range(0, 9)], 8'd1, 1'b0, NO_WANT);
                    send_beat(32'd0, 8'd0, 1'b0, NO_WANT);
                    rnd_sent += 2;
                end
                send_beat(KEY_EQUALS, 8'd1, 1'b0, NO_WANT);
                send_beat(32'd0, 8'd0, 1'b0, NO_WANT);
                rnd_sent += 2;
            end else begin
                sel = $urandom_range(0, 19);
                if (sel < 14) begin
                    key = DIGIT_KEYS[$urandom_range(0, 9)];
                end else if (sel < 17) begin
                    key = KEY_EQUALS;
                end else if (sel < 19) begin
                    key = KEY_MINUS;
                end else begin
                    key = 32'($urandom());
                end
                frames = $urandom_range(1, 4);
                rep    = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'd1;
                for (int f = 0; f < frames; f++) begin
                    code = (f == 0 || $urandom_range(0, 1) == 1) ? key : 32'd0;
                    send_beat(code, rep, 1'b0, NO_WANT);
                    rnd_sent++;
                    if ($urandom_range(0, 2) != 0) begin
                        rep = rep + 8'd1;
                    end
                end
                if ($urandom_range(0, 1) == 1) begin
                    send_beat(32'd0, 8'd0, 1'b0, NO_WANT);
                    rnd_sent++;
                end
            end
            // Once in the run the sender holds off until the result side has
            // caught up completely.
            if (!paused && rnd_sent >= PAUSE_AT) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
